// ===== rtl/xbt_pkg.sv =====
// Package: shared types and constants for the XOR binary trie engine.
`timescale 1ns / 1ps
`default_nettype none
package xbt_pkg;
  localparam int KeyBits   = 32;
  localparam int NodeCount = 65536;
  localparam int NodeW     = $clog2(NodeCount);
  localparam int LinkW     = NodeW + 1;
  localparam int LvlW      = $clog2(KeyBits + 1);
  localparam int CntW      = 32;

  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_ERASE    = 3'd1,
    MODE_CONTAINS = 3'd2,
    MODE_MAX_XOR  = 3'd3,
    MODE_MIN_XOR  = 3'd4,
    MODE_BEST     = 3'd5,
    MODE_CLEAR    = 3'd6,
    MODE_NOP      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,    // pick a child of the held node and issue its read
    S_PCHK,    // look at the first-choice child
    S_ACHK,    // take the alternate child
    S_FLUSH,   // walk broke off: shift in zero result bits
    S_UPDGO,   // restart at the root for the update pass
    S_UPD,     // update pass: write the held node
    S_UPDR,    // update pass: wait for the child read
    S_DONE
  } state_t;

  // One trie node as stored.
  typedef struct packed {
    logic [LinkW-1:0] lz;
    logic [LinkW-1:0] lo;
    logic [CntW-1:0]  cnt;
  } node_t;
endpackage
`default_nettype wire

// ===== rtl/xbt_pool.sv =====
// Node pool memory: one read port and one write port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module xbt_pool (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [xbt_pkg::NodeW-1:0] waddr,
  input  wire xbt_pkg::node_t            wdata,
  input  wire logic [xbt_pkg::NodeW-1:0] raddr,
  output xbt_pkg::node_t                 rdata
);
  xbt_pkg::node_t mem [xbt_pkg::NodeCount];

  // Write and read the pool
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/xbt_keysr.sv =====
// Key shift register: presents one key bit per level, collects result bits.
`timescale 1ns / 1ps
`default_nettype none
module xbt_keysr (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [xbt_pkg::KeyBits-1:0] din,
  input  wire logic                        shift,
  input  wire logic                        rbit,
  output logic                             kbit,
  output logic [xbt_pkg::KeyBits-1:0]      acc
);
  logic [xbt_pkg::KeyBits-1:0] sr;

  assign kbit = sr[xbt_pkg::KeyBits-1];

  // Load key; shift key out MSB first and result bits in
  always_ff @(posedge clk) begin
    if (load) begin
      sr  <= din;
      acc <= '0;
    end else if (shift) begin
      sr  <= {sr[xbt_pkg::KeyBits-2:0], sr[xbt_pkg::KeyBits-1]};
      acc <= {acc[xbt_pkg::KeyBits-2:0], rbit};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/xor_binary_trie_engine_core.sv =====
// Top level: XOR binary trie engine with a walk sequencer over the node pool.
//
// channel  | ports                 | handshake
// ---------+-----------------------+--------------------------------------
// request  | mode, key             | start high while busy low
// result   | value, status         | done high for one cycle, no stall
//
// Contains walks each level through a walk state and a check state; a new
// request is taken once busy is low again after done. Queries may also take
// the alternate child in its own state where the first-choice child is missing
// or empty. Insert and erase add a restart state and an update pass that
// writes each node on the key path, with a wait for each existing child.
// Clear and the unused mode finish in the cycle after acceptance.
// Reset empties the root (held in registers) and sets the free pointer to 1;
// pool nodes are written when allocated. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module xor_binary_trie_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] key,
  output logic             busy,
  output logic             done,
  output logic [31:0]      value,
  output logic [1:0]       status
);
  localparam int NW = xbt_pkg::NodeW;
  localparam int LW = xbt_pkg::LinkW;
  localparam int KB = xbt_pkg::KeyBits;
  localparam int LV = xbt_pkg::LvlW;

  xbt_pkg::state_t  st, st_next;
  xbt_pkg::mode_t   md, md_next;
  xbt_pkg::node_t   nd, nd_next;       // node held for the current level
  xbt_pkg::node_t   root, root_next;
  logic [LW-1:0]    cur, cur_next;
  logic [LW-1:0]    free_ptr, free_ptr_next;
  logic [LV-1:0]    lvl, lvl_next;
  logic [KB-1:0]    keyq, keyq_next;
  xbt_pkg::status_t stat_r, stat_next;
  xbt_pkg::node_t   rd, wdata;
  logic [NW-1:0]    raddr, waddr;
  logic             we;
  logic             kbit, shift, rbit, load;
  logic [KB-1:0]    acc;
  logic [KB-1:0]    key_src;

  xbt_pool u_pool (.clk, .we, .waddr, .wdata, .raddr, .rdata(rd));
  xbt_keysr u_key (.clk, .load, .din(key_src), .shift, .rbit, .kbit, .acc);

  wire is_query = (md == xbt_pkg::MODE_MAX_XOR) || (md == xbt_pkg::MODE_MIN_XOR)
               || (md == xbt_pkg::MODE_BEST);
  wire far = (md != xbt_pkg::MODE_MIN_XOR);
  // First-choice side: away from the key bit for far queries, else along it
  wire side_p = is_query ? (kbit ^ far) : kbit;
  wire [LW-1:0] link_p = side_p ? nd.lo : nd.lz;
  wire [LW-1:0] link_a = side_p ? nd.lz : nd.lo;
  wire last_lvl = (lvl == LV'(1));
  wire root_full = (root.cnt == '1);
  wire need_short = ({1'b0, free_ptr} + (LW+1)'(lvl)) > (LW+1)'(xbt_pkg::NodeCount);

  // Hold state and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= xbt_pkg::S_IDLE;
      md       <= xbt_pkg::MODE_NOP;
      nd       <= '0;
      root     <= '0;
      cur      <= '0;
      free_ptr <= LW'(1);
      lvl      <= '0;
      keyq     <= '0;
      stat_r   <= xbt_pkg::ST_OK;
    end else begin
      st       <= st_next;
      md       <= md_next;
      nd       <= nd_next;
      root     <= root_next;
      cur      <= cur_next;
      free_ptr <= free_ptr_next;
      lvl      <= lvl_next;
      keyq     <= keyq_next;
      stat_r   <= stat_next;
    end
  end

  // Sequencer
  always_comb begin
    st_next       = st;
    md_next       = md;
    nd_next       = nd;
    root_next     = root;
    cur_next      = cur;
    free_ptr_next = free_ptr;
    lvl_next      = lvl;
    keyq_next     = keyq;
    stat_next     = stat_r;
    busy          = (st != xbt_pkg::S_IDLE);
    done          = (st == xbt_pkg::S_DONE);
    load          = 1'b0;
    shift         = 1'b0;
    rbit          = 1'b0;
    we            = 1'b0;
    key_src       = key;
    raddr         = link_p[NW-1:0];
    waddr         = cur[NW-1:0];
    wdata         = nd;
    unique case (st)
      xbt_pkg::S_IDLE: begin
        if (start) begin
          load      = 1'b1;
          md_next   = xbt_pkg::mode_t'(mode);
          keyq_next = key;
          nd_next   = root;
          cur_next  = '0;
          lvl_next  = LV'(KB);
          stat_next = xbt_pkg::ST_OK;
          unique case (xbt_pkg::mode_t'(mode)) inside
            xbt_pkg::MODE_CLEAR: begin
              root_next     = '0;
              free_ptr_next = LW'(1);
              st_next       = xbt_pkg::S_DONE;
            end
            xbt_pkg::MODE_INSERT: st_next = xbt_pkg::S_WALK;
            xbt_pkg::MODE_ERASE, xbt_pkg::MODE_CONTAINS, xbt_pkg::MODE_MAX_XOR,
            xbt_pkg::MODE_MIN_XOR, xbt_pkg::MODE_BEST: begin
              // Drop at once on an empty set
              if (root.cnt == '0) begin
                stat_next = xbt_pkg::ST_MISS;
                st_next   = xbt_pkg::S_DONE;
              end else begin
                st_next = xbt_pkg::S_WALK;
              end
            end
            default: st_next = xbt_pkg::S_DONE;
          endcase
        end
      end
      xbt_pkg::S_WALK: begin
        if (md == xbt_pkg::MODE_INSERT && link_p == '0) begin
          // First missing link: lvl new nodes are needed
          if (root_full || need_short) begin
            stat_next = xbt_pkg::ST_FULL;
            st_next   = xbt_pkg::S_DONE;
          end else begin
            st_next = xbt_pkg::S_UPDGO;
          end
        end else if (link_p != '0) begin
          st_next = xbt_pkg::S_PCHK;
        end else if (is_query && link_a != '0) begin
          raddr   = link_a[NW-1:0];
          st_next = xbt_pkg::S_ACHK;
        end else if (is_query) begin
          st_next = xbt_pkg::S_FLUSH;
        end else begin
          stat_next = xbt_pkg::ST_MISS;
          st_next   = xbt_pkg::S_DONE;
        end
      end
      xbt_pkg::S_PCHK: begin
        if (md == xbt_pkg::MODE_INSERT || rd.cnt != '0) begin
          // Advance into the first-choice child
          nd_next  = rd;
          shift    = 1'b1;
          rbit     = far;
          lvl_next = lvl - LV'(1);
          if (!last_lvl) begin
            st_next = xbt_pkg::S_WALK;
          end else if (md == xbt_pkg::MODE_INSERT) begin
            if (root_full) begin
              stat_next = xbt_pkg::ST_FULL;
              st_next   = xbt_pkg::S_DONE;
            end else begin
              st_next = xbt_pkg::S_UPDGO;
            end
          end else if (md == xbt_pkg::MODE_ERASE) begin
            st_next = xbt_pkg::S_UPDGO;
          end else begin
            st_next = xbt_pkg::S_DONE;
          end
        end else if (is_query && link_a != '0) begin
          raddr   = link_a[NW-1:0];
          st_next = xbt_pkg::S_ACHK;
        end else if (is_query) begin
          st_next = xbt_pkg::S_FLUSH;
        end else begin
          stat_next = xbt_pkg::ST_MISS;
          st_next   = xbt_pkg::S_DONE;
        end
      end
      xbt_pkg::S_ACHK: begin
        nd_next  = rd;
        shift    = 1'b1;
        rbit     = !far;
        lvl_next = lvl - LV'(1);
        st_next  = last_lvl ? xbt_pkg::S_DONE : xbt_pkg::S_WALK;
      end
      xbt_pkg::S_FLUSH: begin
        shift    = 1'b1;
        lvl_next = lvl - LV'(1);
        st_next  = last_lvl ? xbt_pkg::S_DONE : xbt_pkg::S_FLUSH;
      end
      xbt_pkg::S_UPDGO: begin
        // Reload the key and start again at the root
        load     = 1'b1;
        key_src  = keyq;
        nd_next  = root;
        cur_next = '0;
        lvl_next = LV'(KB);
        st_next  = xbt_pkg::S_UPD;
      end
      xbt_pkg::S_UPD: begin
        // Adjust the count; link or allocate the child on the key side
        if (md == xbt_pkg::MODE_INSERT) wdata.cnt = nd.cnt + xbt_pkg::CntW'(1);
        else wdata.cnt = nd.cnt - xbt_pkg::CntW'(1);
        if (lvl == '0) begin
          st_next = xbt_pkg::S_DONE;
        end else begin
          shift    = 1'b1;
          lvl_next = lvl - LV'(1);
          if (md == xbt_pkg::MODE_INSERT && link_p == '0) begin
            if (kbit) wdata.lo = free_ptr;
            else wdata.lz = free_ptr;
            free_ptr_next = free_ptr + LW'(1);
            cur_next      = free_ptr;
            nd_next       = '0;
          end else begin
            cur_next = link_p;
            st_next  = xbt_pkg::S_UPDR;
          end
        end
        if (cur == '0) root_next = wdata;
        else we = 1'b1;
      end
      xbt_pkg::S_UPDR: begin
        nd_next = rd;
        st_next = xbt_pkg::S_UPD;
      end
      xbt_pkg::S_DONE: st_next = xbt_pkg::S_IDLE;
      default: st_next = xbt_pkg::S_IDLE;
    endcase
  end

  // Drive the result for one cycle
  always_comb begin
    status = stat_r;
    value = '0;
    if (done && is_query && stat_r == xbt_pkg::ST_OK) begin
      value = (md == xbt_pkg::MODE_BEST) ? (acc ^ keyq) : acc;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/xbt_check.sv =====
// Port checker for the XOR binary trie engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module xbt_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] value,
  input wire logic [1:0]  status
);
  // Accepted item makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy did not rise");
  // Result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  // Status code is legal
  a_stat: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == xbt_pkg::ST_OK || status == xbt_pkg::ST_MISS
              || status == xbt_pkg::ST_FULL)) else $error("bad status");
  // Failed request carries zero value
  a_val: assert property (@(posedge clk) disable iff (rst)
    (done && status != xbt_pkg::ST_OK) |-> (value == 32'd0)) else $error("value not zero");
endmodule

bind xor_binary_trie_engine_core xbt_check u_check (
  .clk, .rst, .start, .busy, .done, .value, .status
);
`default_nettype wire
